[design/ulx_pkg.sv]
// Shared types, constants and byte-class functions of the lenient UTF-8 decoder.
// No dependencies; every other design file imports this package.
package ulx_pkg;

    localparam int BYTE_W     = 8;
    localparam int CP_W       = 21;
    localparam int M_TDATA_W  = 24;
    localparam int CP_PAD_W   = M_TDATA_W - CP_W;
    localparam int MAX_RES    = 4;
    localparam int HELD_DEPTH = 3;

    // byte class masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    // payload bit masks
    localparam logic [7:0] TAIL_MASK  = 8'h3F;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD4_BITS = 8'h07;

    // sequence lengths
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CP_W-1:0]   cp_t;
    typedef logic [2:0]        res_cnt_t;
    typedef logic [1:0]        held_cnt_t;

    // results caused by one input byte, in order from slot 0
    typedef struct packed {
        res_cnt_t              count;
        cp_t [MAX_RES-1:0]     cp;
    } batch_t;

    // one result on its way to the output
    typedef struct packed {
        logic last;
        cp_t  cp;
    } beat_t;

    // number of bytes a sequence opened by this byte spans (1 if not a lead)
    function automatic res_cnt_t seq_len(input byte_t b);
        res_cnt_t len;
        len = LEN_ONE;
        if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            len = LEN_TWO;
        end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            len = LEN_THREE;
        end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    function automatic logic is_cont(input byte_t b);
        return (b & CONT_MASK) == CONT_PAT;
    endfunction

    function automatic cp_t zext_byte(input byte_t b);
        return {{(CP_W-BYTE_W){1'b0}}, b};
    endfunction

endpackage

[design/ulx_core.sv]
// Decode logic and sequence state: turns one registered byte into a batch of results.
// Depends on ulx_pkg.
module ulx_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           fire,
    input  ulx_pkg::byte_t byte_i,
    input  logic           end_i,
    output ulx_pkg::batch_t batch
);
    import ulx_pkg::*;

    byte_t     held_reg [HELD_DEPTH];
    byte_t     held_next [HELD_DEPTH];
    held_cnt_t cnt_reg;
    held_cnt_t cnt_next;

    logic     cont;
    logic     complete;
    logic     extend;
    res_cnt_t need;
    res_cnt_t blen;
    res_cnt_t cnt_plus1;
    cp_t      seq_cp;

    // classify the byte against the open sequence
    always_comb begin
        cont      = is_cont(byte_i);
        need      = seq_len(held_reg[0]);
        blen      = seq_len(byte_i);
        cnt_plus1 = {1'b0, cnt_reg} + 3'd1;
        complete  = (cnt_reg != 2'd0) && cont && (cnt_plus1 >= need);
        extend    = (cnt_reg != 2'd0) && cont && !complete;
    end

    // assemble the finished code point
    always_comb begin
        case (need)
            LEN_TWO: begin
                seq_cp = {10'd0, held_reg[0][4:0] & LEAD2_BITS[4:0], byte_i[5:0]};
            end
            LEN_THREE: begin
                seq_cp = {5'd0, held_reg[0][3:0] & LEAD3_BITS[3:0],
                          held_reg[1][5:0] & TAIL_MASK[5:0], byte_i[5:0]};
            end
            default: begin
                seq_cp = {held_reg[0][2:0] & LEAD4_BITS[2:0],
                          held_reg[1][5:0] & TAIL_MASK[5:0],
                          held_reg[2][5:0] & TAIL_MASK[5:0], byte_i[5:0]};
            end
        endcase
    end

    // result list and next state: held bytes first, then the new byte
    always_comb begin
        for (int i = 0; i < HELD_DEPTH; i++) begin
            held_next[i] = held_reg[i];
            batch.cp[i]  = (i < int'(cnt_reg)) ? zext_byte(held_reg[i]) : zext_byte(byte_i);
        end
        batch.cp[MAX_RES-1] = zext_byte(byte_i);
        batch.count = 3'd0;
        cnt_next    = cnt_reg;
        if (complete) begin
            batch.cp[0] = seq_cp;
            batch.count = 3'd1;
            cnt_next    = 2'd0;
        end else if (extend) begin
            if (cnt_reg == 2'd1) begin
                held_next[1] = byte_i;
            end else begin
                held_next[2] = byte_i;
            end
            if (end_i) begin
                batch.count = cnt_plus1;
                cnt_next    = 2'd0;
            end else begin
                cnt_next    = cnt_plus1[1:0];
            end
        end else if (blen == LEN_ONE || end_i) begin
            // broken or no sequence; the new byte goes out raw
            batch.count = cnt_plus1;
            cnt_next    = 2'd0;
        end else begin
            // new lead byte opens a sequence after any flush
            batch.count  = {1'b0, cnt_reg};
            held_next[0] = byte_i;
            cnt_next     = 2'd1;
        end
    end

    // held bytes carry no reset; entries past the count are never read
    always_ff @(posedge aclk) begin
        if (fire) begin
            for (int i = 0; i < HELD_DEPTH; i++) begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (fire) begin
            cnt_reg <= cnt_next;
        end
    end

    // an open sequence always starts with a lead byte
    a_held_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 2'd0) |-> (seq_len(held_reg[0]) != LEN_ONE))
        else $error("open sequence without a lead byte");

    // end of stream leaves nothing held
    a_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && end_i) |=> (cnt_reg == 2'd0))
        else $error("bytes held after end of stream");

endmodule

[design/ulx_serializer.sv]
// Result register: holds one byte's batch of results and hands them out one
// per cycle while beat_ready is high. Depends on ulx_pkg.
module ulx_serializer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  ulx_pkg::batch_t batch,
    output logic            ready,
    output logic            beat_valid,
    output ulx_pkg::beat_t  beat,
    input  logic            beat_ready
);
    import ulx_pkg::*;

    cp_t      slot_reg [MAX_RES];
    res_cnt_t cnt_reg;
    logic     pop;

    // a new batch fits once the last pending result leaves
    always_comb begin
        pop        = (cnt_reg != 3'd0) && beat_ready;
        ready      = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && beat_ready);
        beat_valid = (cnt_reg != 3'd0);
        beat.cp    = slot_reg[0];
        beat.last  = (cnt_reg == 3'd1);
    end

    // result slots, shifted toward slot 0 as results leave
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < MAX_RES; i++) begin
                slot_reg[i] <= batch.cp[i];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else if (load) begin
            cnt_reg <= batch.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    // never more results pending than one byte can cause
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= res_cnt_t'(MAX_RES))
        else $error("result count out of range");

endmodule

[design/ulx_skid.sv]
// Output register with a skid slot so that upstream ready comes from a flop.
// Depends on ulx_pkg.
module ulx_skid (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           up_valid,
    input  ulx_pkg::beat_t up_beat,
    output logic           up_ready,
    output logic           dn_valid,
    output ulx_pkg::beat_t dn_beat,
    input  logic           dn_ready
);
    import ulx_pkg::*;

    logic  out_valid_reg;
    beat_t out_beat_reg;
    logic  skid_valid_reg;
    beat_t skid_beat_reg;
    logic  advance;

    assign up_ready = !skid_valid_reg;
    assign dn_valid = out_valid_reg;
    assign dn_beat  = out_beat_reg;
    assign advance  = dn_ready || !out_valid_reg;

    // output register takes the skid slot first, else the upstream request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (advance) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= up_valid;
            end
        end else if (up_valid && up_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_beat_reg <= skid_valid_reg ? skid_beat_reg : up_beat;
        end else if (up_valid && up_ready) begin
            skid_beat_reg <= up_beat;
        end
    end

    // the skid slot fills only behind a full output register
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output register empty");

endmodule

[design/utf8_lenient_decoder.sv]
// Top level of the lenient UTF-8 decoder: input register, decode core, result
// serializer and output skid register. Depends on ulx_pkg and the ulx_* modules.
//
// Takes one byte per cycle (tlast marks the end of a stream) and returns code
// points one per cycle, with tlast on the last result a byte causes, while the
// output is not stalled. A byte that causes several results holds the input
// until its last result leaves the result register, since the single output
// port sends one result per cycle; bytes with zero or one result flow at one
// per cycle. Results pass the input, result and output registers in turn.
module utf8_lenient_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ulx_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] byte_in
    input  logic                        s_tlast,   // stream_end
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ulx_pkg::M_TDATA_W-1:0] m_tdata, // [20:0] code_point, [23:21] zero
    output logic                        m_tlast    // run_last
);
    import ulx_pkg::*;

    logic   in_valid_reg;
    byte_t  in_byte_reg;
    logic   in_end_reg;
    logic   ser_ready;
    logic   fire;
    batch_t batch;
    logic   beat_valid;
    beat_t  beat;
    logic   skid_ready;
    beat_t  out_beat;

    assign fire     = in_valid_reg && ser_ready;
    assign s_tready = !in_valid_reg || ser_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    ulx_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .byte_i  (in_byte_reg),
        .end_i   (in_end_reg),
        .batch   (batch)
    );

    ulx_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .batch      (batch),
        .ready      (ser_ready),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_ready (skid_ready)
    );

    ulx_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (beat_valid),
        .up_beat  (beat),
        .up_ready (skid_ready),
        .dn_valid (m_tvalid),
        .dn_beat  (out_beat),
        .dn_ready (m_tready)
    );

    assign m_tdata = {{CP_PAD_W{1'b0}}, out_beat.cp};
    assign m_tlast = out_beat.last;

endmodule

[verif/utf8_lenient_decoder_test.sv]
// Self-checking testbench for utf8_lenient_decoder: a directed sweep of byte classes and
// sequence shapes, then random byte runs under three handshake idling mixes.
// Depends on ulx_pkg and the design files of the decoder.
module utf8_lenient_decoder_test;
    import ulx_pkg::*;

    localparam int  DIR_ROWS       = 25;
    localparam int  LONG_STALL     = 150;
    localparam int  WATCHDOG_LIMIT = 1500;
    localparam int  DRAIN_CYCLES   = 20;
    localparam logic TYPED         = 1'b1;
    localparam logic FROM_MODEL    = 1'b0;

    // one stimulus byte, optionally with its code points typed in
    typedef struct packed {
        byte_t      b;
        logic       e;
        logic       typed;
        logic [2:0] n;
        cp_t        c0;
        cp_t        c1;
        cp_t        c2;
        cp_t        c3;
    } byte_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // decoder state as predicted
    byte_t held_seq [HELD_DEPTH];
    int    held_num;

    beat_t     expected_points [$];
    byte_row_t byte_plan [$];
    int        src_idle_pct;
    int        sink_idle_pct;
    int        stall_asked;
    int        stall_done;
    int        quiet_cycles;
    int        mismatches;
    int        bytes_sent;
    int        ends_sent;
    int        points_seen;

    // directed sweep: byte classes, extremes, broken and cut-off sequences
    byte_row_t sweep_rows [DIR_ROWS] = '{
        '{8'h00, 1'b0, TYPED, 3'd1, 21'h00, 21'h0, 21'h0, 21'h0},      // ascii low
        '{8'h7F, 1'b0, TYPED, 3'd1, 21'h7F, 21'h0, 21'h0, 21'h0},      // ascii high
        '{8'h80, 1'b0, TYPED, 3'd1, 21'h80, 21'h0, 21'h0, 21'h0},      // stray continuation
        '{8'hBF, 1'b0, TYPED, 3'd1, 21'hBF, 21'h0, 21'h0, 21'h0},
        '{8'hF8, 1'b0, TYPED, 3'd1, 21'hF8, 21'h0, 21'h0, 21'h0},      // invalid lead
        '{8'hFF, 1'b0, TYPED, 3'd1, 21'hFF, 21'h0, 21'h0, 21'h0},
        '{8'hC2, 1'b0, TYPED, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},       // two-byte form
        '{8'hA9, 1'b0, TYPED, 3'd1, 21'hA9, 21'h0, 21'h0, 21'h0},
        '{8'hF7, 1'b0, TYPED, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},       // largest four-byte
        '{8'hBF, 1'b0, TYPED, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},
        '{8'hBF, 1'b0, TYPED, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},
        '{8'hBF, 1'b0, TYPED, 3'd1, 21'h1FFFFF, 21'h0, 21'h0, 21'h0},
        '{8'hED, 1'b0, FROM_MODEL, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},  // surrogate passes
        '{8'hA0, 1'b0, FROM_MODEL, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},
        '{8'h80, 1'b0, FROM_MODEL, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},
        '{8'hF0, 1'b0, TYPED, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},       // broken by ascii
        '{8'h90, 1'b0, TYPED, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},
        '{8'h80, 1'b0, TYPED, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},
        '{8'h41, 1'b0, TYPED, 3'd4, 21'hF0, 21'h90, 21'h80, 21'h41},
        '{8'hE0, 1'b1, TYPED, 3'd1, 21'hE0, 21'h0, 21'h0, 21'h0},      // lead at end of stream
        '{8'hE1, 1'b0, TYPED, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},       // cut off by end
        '{8'h80, 1'b1, TYPED, 3'd2, 21'hE1, 21'h80, 21'h0, 21'h0},
        '{8'hC3, 1'b0, FROM_MODEL, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},  // broken by a new lead
        '{8'hC3, 1'b0, FROM_MODEL, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0},
        '{8'hA9, 1'b0, FROM_MODEL, 3'd0, 21'h0, 21'h0, 21'h0, 21'h0}
    };

    utf8_lenient_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // length of the sequence a byte opens, 1 when it opens none
    function automatic int lead_len(input byte_t b);
        casez (b)
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 1;
        endcase
    endfunction

    // code points caused by one accepted byte, updates the held sequence
    function automatic int decode_byte(input byte_t b, input logic e,
                                       output cp_t pts [MAX_RES]);
        int   n;
        int   i;
        int   need;
        logic fresh;
        n = 0;
        fresh = 1'b1;
        for (i = 0; i < MAX_RES; i++) pts[i] = '0;
        if (held_num != 0) begin
            if (b[7:6] == 2'b10) begin
                fresh = 1'b0;
                need = lead_len(held_seq[0]);
                if (held_num + 1 >= need) begin
                    case (need)
                        2: pts[n] = cp_t'({held_seq[0][4:0], b[5:0]});
                        3: pts[n] = cp_t'({held_seq[0][3:0], held_seq[1][5:0], b[5:0]});
                        default: pts[n] = {held_seq[0][2:0], held_seq[1][5:0],
                                           held_seq[2][5:0], b[5:0]};
                    endcase
                    n++;
                    held_num = 0;
                end else begin
                    held_seq[held_num] = b;
                    held_num++;
                    // cut off at end of stream: every held byte comes out raw
                    if (e) begin
                        for (i = 0; i < held_num; i++) begin
                            pts[n] = cp_t'(held_seq[i]);
                            n++;
                        end
                        held_num = 0;
                    end
                end
            end else begin
                // broken sequence: held bytes come out raw before the new byte
                for (i = 0; i < held_num; i++) begin
                    pts[n] = cp_t'(held_seq[i]);
                    n++;
                end
                held_num = 0;
            end
        end
        if (fresh) begin
            if (lead_len(b) == 1 || e) begin
                pts[n] = cp_t'(b);
                n++;
            end else begin
                held_seq[0] = b;
                held_num = 1;
            end
        end
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // offer one byte, then queue the code points it causes once the request is taken
    task automatic push_byte(input byte_row_t row);
        cp_t   pts [MAX_RES];
        int    n;
        int    i;
        beat_t bt;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.b;
        s_tlast  <= row.e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = decode_byte(row.b, row.e, pts);
        if (row.typed) begin
            n = row.n;
            pts[0] = row.c0;
            pts[1] = row.c1;
            pts[2] = row.c2;
            pts[3] = row.c3;
        end
        for (i = 0; i < n; i++) begin
            bt.cp   = pts[i];
            bt.last = (i == n - 1);
            expected_points = {expected_points, bt};
        end
        bytes_sent++;
        if (row.e) ends_sent++;
    endtask

    task automatic plan_byte(input byte_t b);
        byte_row_t row;
        row = '0;
        row.b = b;
        row.e = ($urandom_range(99) < 5);
        row.typed = FROM_MODEL;
        byte_plan = {byte_plan, row};
    endtask

    // one run: mostly well-formed sequences, some broken ones, some raw noise
    task automatic plan_run();
        int    kind;
        int    len;
        int    conts;
        int    i;
        byte_t lead;
        byte_t tail;
        kind = $urandom_range(99);
        if (kind < 20) begin
            plan_byte(8'($urandom));
        end else begin
            len = $urandom_range(1, 4);
            case (len)
                1:       lead = {1'b0, 7'($urandom)};
                2:       lead = {3'b110, 5'($urandom)};
                3:       lead = {4'b1110, 4'($urandom)};
                default: lead = {5'b11110, 3'($urandom)};
            endcase
            conts = len - 1;
            if (kind >= 80 && len > 1) conts = $urandom_range(0, len - 2);
            plan_byte(lead);
            for (i = 0; i < conts; i++) plan_byte({2'b10, 6'($urandom)});
            if (kind >= 80 && len > 1) begin
                tail = 8'($urandom);
                if (tail[7:6] == 2'b10) tail[6] = 1'b1;
                plan_byte(tail);
            end
        end
    endtask

    task automatic run_random(input int n_items);
        byte_plan.delete();
        while (byte_plan.size() < n_items) plan_run();
        foreach (byte_plan[i]) push_byte(byte_plan[i]);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int k;
        forever begin
            @(posedge aclk);
            if (stall_asked != stall_done) begin
                stall_done++;
                m_tready <= 1'b0;
                for (k = 0; k < LONG_STALL; k++) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // compare each code point against the oldest expectation
    always @(posedge aclk) begin : point_check
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("code point %h with none expected",
                                          m_tdata[CP_W-1:0]));
            end else begin
                want = expected_points.pop_front();
                if (m_tdata[CP_W-1:0] !== want.cp)
                    report_mismatch($sformatf("code point %h, expected %h",
                                              m_tdata[CP_W-1:0], want.cp));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last flag %b on %h, expected %b",
                                              m_tlast, want.cp, want.last));
            end
        end
    end

    // watchdog on cycles with no request taken on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d code points pending",
                     quiet_cycles, expected_points.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        held_seq     = '{default: '0};
        held_num     = 0;
        src_idle_pct  = 17;
        sink_idle_pct = 83;
        stall_asked  = 0;
        stall_done   = 0;
        quiet_cycles = 0;
        mismatches   = 0;
        bytes_sent   = 0;
        ends_sent    = 0;
        points_seen  = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed sweep, then random runs under a slow receiver
        foreach (sweep_rows[i]) push_byte(sweep_rows[i]);
        run_random(115);

        // slow sender
        src_idle_pct  = 83;
        sink_idle_pct = 17;
        run_random(115);

        // no idling, with one long receiver hold-off to back up the input
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_asked++;
        run_random(115);

        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d input bytes (%0d stream ends) and %0d code points",
                 bytes_sent, ends_sent, points_seen);
        $display("under slow-receiver, slow-sender and full-rate mixes with one long stall");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[utf8_lenient_decoder.f]
design/ulx_pkg.sv
design/ulx_core.sv
design/ulx_serializer.sv
design/ulx_skid.sv
design/utf8_lenient_decoder.sv
verif/utf8_lenient_decoder_test.sv
